### rtl/ifd_pkg.sv
// Shared types, constants and the byte-wide CRC-16/MODBUS update for the IMU frame deframer.
package ifd_pkg;

	localparam logic [7:0]  HDR0       = 8'hA5;
	localparam logic [7:0]  HDR1       = 8'h5A;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam int          STORE_DEPTH = 32;
	localparam int          POS_W      = 6;
	localparam logic [POS_W-1:0] POS_HUNT  = 6'd0;
	localparam logic [POS_W-1:0] POS_HDR1  = 6'd1;
	localparam logic [POS_W-1:0] POS_DATA0 = 6'd2;
	localparam logic [POS_W-1:0] POS_CRCLO = 6'd34;
	localparam logic [POS_W-1:0] POS_CRCHI = 6'd35;
	localparam logic [POS_W-1:0] FRAME_LEN = 6'd36;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [31:0] quat_w0_bits;
		logic [31:0] quat_w1_bits;
		logic [31:0] quat_w2_bits;
		logic [31:0] quat_w3_bits;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
		logic [15:0] gyro_x;
		logic [15:0] gyro_y;
		logic [15:0] gyro_z;
		logic [15:0] wheel_right_count;
		logic [15:0] wheel_left_count;
	} frame_t;

	// Status from the parser to the result register.
	typedef struct packed {
		logic emit;
		logic at_check;
	} parse_stat_t;

	// Reflected CRC-16 update over one byte, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input byte_t b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (r[0])
				r = (r >> 1) ^ CRC_POLY;
			else
				r = r >> 1;
		end
		return r;
	endfunction

endpackage

### rtl/ifd_parser.sv
// Header hunt, frame byte capture and running CRC check of the IMU frame deframer.
module ifd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  ifd_pkg::byte_t      rx_byte,
	output ifd_pkg::parse_stat_t stat,
	output ifd_pkg::frame_t     frame
);
	import ifd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	byte_t            crc_lo_q;
	byte_t            store_q [STORE_DEPTH];

	logic [POS_W-1:0] pos_d;
	logic [15:0]      crc_d;
	logic [15:0]      crc_upd;
	logic [15:0]      crc_from_init;
	logic             hunting;
	logic             crc_ok;

	assign crc_upd       = crc16_byte(crc_q, rx_byte);
	assign crc_from_init = crc16_byte(CRC_INIT, rx_byte);
	assign hunting       = (pos_q == POS_HUNT) || (pos_q >= FRAME_LEN);
	assign crc_ok        = (crc_lo_q == crc_q[7:0]) && (rx_byte == crc_q[15:8]);

	assign stat.at_check = (pos_q == POS_CRCHI);
	assign stat.emit     = take && stat.at_check && crc_ok;

	always_comb begin
		pos_d = POS_HUNT;
		crc_d = CRC_INIT;
		if (hunting) begin
			if (rx_byte == HDR0) begin
				pos_d = POS_HDR1;
				crc_d = crc_from_init;
			end
		end else if (pos_q == POS_HDR1) begin
			if (rx_byte == HDR1) begin
				pos_d = POS_DATA0;
				crc_d = crc_upd;
			end else if (rx_byte == HDR0) begin
				pos_d = POS_HDR1;
				crc_d = crc_from_init;
			end
		end else if (pos_q < POS_CRCLO) begin
			pos_d = pos_q + 1'b1;
			crc_d = crc_upd;
		end else if (pos_q == POS_CRCLO) begin
			pos_d = pos_q + 1'b1;
			crc_d = crc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT;
			crc_q    <= CRC_INIT;
			crc_lo_q <= '0;
		end else if (take) begin
			pos_q <= pos_d;
			crc_q <= crc_d;
			if (pos_q == POS_CRCLO)
				crc_lo_q <= rx_byte;
		end
	end

	// Payload bytes 2 to 33 land at entry (position - 2).
	always_ff @(posedge clk) begin
		if (take && !hunting && pos_q >= POS_DATA0 && pos_q < POS_CRCLO)
			store_q[5'(pos_q - POS_DATA0)] <= rx_byte;
	end

	always_comb begin
		frame.quat_w0_bits      = {store_q[3],  store_q[2],  store_q[1],  store_q[0]};
		frame.quat_w1_bits      = {store_q[7],  store_q[6],  store_q[5],  store_q[4]};
		frame.quat_w2_bits      = {store_q[11], store_q[10], store_q[9],  store_q[8]};
		frame.quat_w3_bits      = {store_q[15], store_q[14], store_q[13], store_q[12]};
		frame.accel_x           = {store_q[17], store_q[16]};
		frame.accel_y           = {store_q[19], store_q[18]};
		frame.accel_z           = {store_q[21], store_q[20]};
		frame.gyro_x            = {store_q[23], store_q[22]};
		frame.gyro_y            = {store_q[25], store_q[24]};
		frame.gyro_z            = {store_q[27], store_q[26]};
		frame.wheel_right_count = {store_q[29], store_q[28]};
		frame.wheel_left_count  = {store_q[31], store_q[30]};
	end

endmodule

### rtl/ifd_out_reg.sv
// Result register of the IMU frame deframer and the input ready that guards it.
module ifd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifd_pkg::parse_stat_t stat,
	input  ifd_pkg::frame_t      frame,
	input  logic                 out_ready,
	output logic                 in_ready,
	output logic                 out_valid,
	output ifd_pkg::frame_t      res
);
	import ifd_pkg::*;

	logic    valid_q;
	frame_t  res_q;

	// Only the CRC high byte can produce a result, so only that byte waits for room.
	assign in_ready  = !valid_q || out_ready || !stat.at_check;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (stat.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.emit)
			res_q <= frame;
	end

endmodule

### rtl/imu_frame_deframer_crc16.sv
// Top level of the byte-serial IMU frame deframer with CRC-16/MODBUS check.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | rx_byte (8 bits)
//  out     | out_valid / out_ready| quat_w0..3_bits, accel, gyro, wheel counts
//
// One byte is taken per cycle while in_ready is high; the frame's result is
// registered and offered in the cycle after its CRC high byte is taken.
// Reset clears the hunt position, CRC and result valid; no clearing pass.
// While a result waits, bytes keep flowing except a next CRC high byte.
module imu_frame_deframer_crc16 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        quat_w0_bits,
	output logic [31:0]        quat_w1_bits,
	output logic [31:0]        quat_w2_bits,
	output logic [31:0]        quat_w3_bits,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] wheel_right_count,
	output logic signed [15:0] wheel_left_count
);
	import ifd_pkg::*;

	parse_stat_t stat;
	frame_t      frame;
	frame_t      res;
	logic        take;

	assign take = in_valid && in_ready;

	ifd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.stat    (stat),
		.frame   (frame)
	);

	ifd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.frame     (frame),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign quat_w0_bits      = res.quat_w0_bits;
	assign quat_w1_bits      = res.quat_w1_bits;
	assign quat_w2_bits      = res.quat_w2_bits;
	assign quat_w3_bits      = res.quat_w3_bits;
	assign accel_x           = $signed(res.accel_x);
	assign accel_y           = $signed(res.accel_y);
	assign accel_z           = $signed(res.accel_z);
	assign gyro_x            = $signed(res.gyro_x);
	assign gyro_y            = $signed(res.gyro_y);
	assign gyro_z            = $signed(res.gyro_z);
	assign wheel_right_count = $signed(res.wheel_right_count);
	assign wheel_left_count  = $signed(res.wheel_left_count);

endmodule

### rtl/ifd_checker.sv
// Port-level checks for the IMU frame deframer, bound to its top level.
module ifd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] quat_w0_bits
);

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quat_w0_bits))
		else $error("result changed while stalled");

	// A new result only follows an accepted byte.
	a_rose_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted item");

	// Input is held back only while a result waits.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with no waiting result");

endmodule

bind imu_frame_deframer_crc16 ifd_checker u_ifd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.quat_w0_bits (quat_w0_bits)
);

### sim/imu_frame_deframer_crc16_tb.sv
// Self-checking testbench for the IMU frame deframer with CRC-16/MODBUS check.
`timescale 1ns / 100ps

module imu_frame_deframer_crc16_tb;
	import ifd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 1450;
	localparam int PRINT_CAP    = 100;

	typedef enum int {CRC_GOOD, CRC_BAD_LOW, CRC_BAD_HIGH} crc_fault_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        quat_w0_bits;
	logic [31:0]        quat_w1_bits;
	logic [31:0]        quat_w2_bits;
	logic [31:0]        quat_w3_bits;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] wheel_right_count;
	logic signed [15:0] wheel_left_count;

	imu_frame_deframer_crc16 dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.quat_w0_bits      (quat_w0_bits),
		.quat_w1_bits      (quat_w1_bits),
		.quat_w2_bits      (quat_w2_bits),
		.quat_w3_bits      (quat_w3_bits),
		.accel_x           (accel_x),
		.accel_y           (accel_y),
		.accel_z           (accel_z),
		.gyro_x            (gyro_x),
		.gyro_y            (gyro_y),
		.gyro_z            (gyro_z),
		.wheel_right_count (wheel_right_count),
		.wheel_left_count  (wheel_left_count)
	);

	// Predictor state.
	logic [POS_W-1:0] frame_pos;
	logic [15:0]      running_crc;
	byte_t            payload_bytes [STORE_DEPTH];
	byte_t            crc_low_byte;
	frame_t           expected_frames [$];

	// Stimulus and pacing controls.
	byte_t body_bytes [STORE_DEPTH];
	bit    idle_in;
	bit    idle_out;
	bit    hold_req;
	int    hold_cycles;
	int    bytes_sent;
	int    errors;
	int    cycle_count;

	string field_names [12] = '{"quat_w0_bits", "quat_w1_bits", "quat_w2_bits",
		"quat_w3_bits", "accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z",
		"wheel_right_count", "wheel_left_count"};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_modbus_step(logic [15:0] acc, byte_t b);
		logic [15:0] r;
		r = acc ^ {8'h00, b};
		repeat (8)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic logic [31:0] store_le32(int off);
		return {payload_bytes[off + 3], payload_bytes[off + 2],
			payload_bytes[off + 1], payload_bytes[off]};
	endfunction

	function automatic logic [15:0] store_le16(int off);
		return {payload_bytes[off + 1], payload_bytes[off]};
	endfunction

	function automatic logic [31:0] frame_field(frame_t f, int k);
		case (k)
			0:  return f.quat_w0_bits;
			1:  return f.quat_w1_bits;
			2:  return f.quat_w2_bits;
			3:  return f.quat_w3_bits;
			4:  return {16'h0000, f.accel_x};
			5:  return {16'h0000, f.accel_y};
			6:  return {16'h0000, f.accel_z};
			7:  return {16'h0000, f.gyro_x};
			8:  return {16'h0000, f.gyro_y};
			9:  return {16'h0000, f.gyro_z};
			10: return {16'h0000, f.wheel_right_count};
			default: return {16'h0000, f.wheel_left_count};
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Advances the deframer state by one accepted byte and queues a frame on a CRC match.
	task automatic deframe_byte(input byte_t b);
		frame_t f;
		int     idx;
		if (frame_pos == POS_HUNT || frame_pos >= FRAME_LEN) begin
			frame_pos   = POS_HUNT;
			running_crc = CRC_INIT;
			if (b == HDR0) begin
				running_crc = crc16_modbus_step(CRC_INIT, b);
				frame_pos   = POS_HDR1;
			end
		end else if (frame_pos == POS_HDR1) begin
			if (b == HDR1) begin
				running_crc = crc16_modbus_step(running_crc, b);
				frame_pos   = POS_DATA0;
			end else if (b == HDR0) begin
				// A repeated first header byte restarts the header match.
				running_crc = crc16_modbus_step(CRC_INIT, b);
			end else begin
				frame_pos   = POS_HUNT;
				running_crc = CRC_INIT;
			end
		end else if (frame_pos < POS_CRCLO) begin
			idx = int'(frame_pos) - int'(POS_DATA0);
			payload_bytes[idx] = b;
			running_crc = crc16_modbus_step(running_crc, b);
			frame_pos   = frame_pos + 1'b1;
		end else if (frame_pos == POS_CRCLO) begin
			crc_low_byte = b;
			frame_pos    = frame_pos + 1'b1;
		end else begin
			if (crc_low_byte == running_crc[7:0] && b == running_crc[15:8]) begin
				f.quat_w0_bits      = store_le32(0);
				f.quat_w1_bits      = store_le32(4);
				f.quat_w2_bits      = store_le32(8);
				f.quat_w3_bits      = store_le32(12);
				f.accel_x           = store_le16(16);
				f.accel_y           = store_le16(18);
				f.accel_z           = store_le16(20);
				f.gyro_x            = store_le16(22);
				f.gyro_y            = store_le16(24);
				f.gyro_z            = store_le16(26);
				f.wheel_right_count = store_le16(28);
				f.wheel_left_count  = store_le16(30);
				expected_frames.push_back(f);
			end
			frame_pos   = POS_HUNT;
			running_crc = CRC_INIT;
		end
	endtask

	task automatic check_frame();
		frame_t want;
		frame_t got;
		int     k;
		got = '{quat_w0_bits, quat_w1_bits, quat_w2_bits, quat_w3_bits, accel_x, accel_y,
			accel_z, gyro_x, gyro_y, gyro_z, wheel_right_count, wheel_left_count};
		if (expected_frames.size() == 0) begin
			report_mismatch("result with no good frame pending");
		end else begin
			want = expected_frames.pop_front();
			for (k = 0; k < 12; k++) begin
				if (frame_field(got, k) !== frame_field(want, k))
					report_mismatch($sformatf("%s got 0x%08h expected 0x%08h",
						field_names[k], frame_field(got, k), frame_field(want, k)));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				deframe_byte(rx_byte);
			if (out_valid && out_ready)
				check_frame();
		end
	end

	// Offers one byte and returns right after the edge at which it is taken.
	task automatic send_byte(input byte_t b);
		int gap;
		gap = idle_in ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_frame(input crc_fault_t fault);
		logic [15:0] c;
		byte_t       lo;
		byte_t       hi;
		int          i;
		c = crc16_modbus_step(CRC_INIT, HDR0);
		c = crc16_modbus_step(c, HDR1);
		for (i = 0; i < STORE_DEPTH; i++)
			c = crc16_modbus_step(c, body_bytes[i]);
		lo = c[7:0];
		hi = c[15:8];
		if (fault == CRC_BAD_LOW)
			lo = lo ^ byte_t'($urandom_range(1, 255));
		else if (fault == CRC_BAD_HIGH)
			hi = hi ^ byte_t'($urandom_range(1, 255));
		send_byte(HDR0);
		send_byte(HDR1);
		for (i = 0; i < STORE_DEPTH; i++)
			send_byte(body_bytes[i]);
		send_byte(lo);
		send_byte(hi);
	endtask

	task automatic fill_body(input int mode);
		int i;
		for (i = 0; i < STORE_DEPTH; i++) begin
			case (mode)
				0:       body_bytes[i] = 8'h00;
				1:       body_bytes[i] = 8'hFF;
				default: body_bytes[i] = byte_t'($urandom_range(0, 255));
			endcase
		end
	endtask

	// Garbage before a header, a broken second header byte and a doubled first header byte.
	task automatic test_header_hunt();
		idle_in  = 1'b1;
		idle_out = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR1);
		send_byte(HDR0);
		send_byte(8'h00);
		fill_body(0);
		send_byte(HDR0);
		send_frame(CRC_GOOD);
	endtask

	// An all-ones frame, then fields set to most negative, most positive, zero or one, and all-ones values.
	task automatic test_field_extremes();
		int k;
		fill_body(1);
		send_frame(CRC_GOOD);
		{body_bytes[3], body_bytes[2], body_bytes[1], body_bytes[0]}     = 32'h8000_0000;
		{body_bytes[7], body_bytes[6], body_bytes[5], body_bytes[4]}     = 32'h7FFF_FFFF;
		{body_bytes[11], body_bytes[10], body_bytes[9], body_bytes[8]}   = 32'h0000_0000;
		{body_bytes[15], body_bytes[14], body_bytes[13], body_bytes[12]} = 32'hFFFF_FFFF;
		for (k = 0; k < 8; k++) begin
			case (k % 4)
				0:       {body_bytes[16 + 2*k + 1], body_bytes[16 + 2*k]} = 16'h8000;
				1:       {body_bytes[16 + 2*k + 1], body_bytes[16 + 2*k]} = 16'h7FFF;
				2:       {body_bytes[16 + 2*k + 1], body_bytes[16 + 2*k]} = 16'h0001;
				default: {body_bytes[16 + 2*k + 1], body_bytes[16 + 2*k]} = 16'hFFFF;
			endcase
		end
		send_frame(CRC_GOOD);
	endtask

	// Bad CRC bytes drop the frame; a header inside a dropped frame is not rescanned.
	task automatic test_crc_errors();
		fill_body(2);
		send_frame(CRC_BAD_LOW);
		send_frame(CRC_BAD_HIGH);
		fill_body(2);
		body_bytes[10] = HDR0;
		body_bytes[11] = HDR1;
		send_frame(CRC_BAD_LOW);
		fill_body(2);
		send_frame(CRC_GOOD);
	endtask

	// Receiver holds off for a long stretch so that held results stall the input.
	task automatic test_backpressure();
		int n;
		idle_in     = 1'b0;
		idle_out    = 1'b0;
		hold_cycles = 400;
		hold_req    = 1'b1;
		for (n = 0; n < 4; n++) begin
			fill_body(2);
			send_frame(CRC_GOOD);
		end
	endtask

	task automatic test_random_stream();
		int pick;
		int n;
		int i;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			idle_in  = ($urandom_range(0, 3) != 0);
			idle_out = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				fill_body(2);
				send_frame(CRC_GOOD);
			end else if (pick < 77) begin
				fill_body(2);
				send_frame(pick[0] ? CRC_BAD_LOW : CRC_BAD_HIGH);
			end else if (pick < 90) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 3))
						0:       send_byte(HDR0);
						1:       send_byte(HDR1);
						default: send_byte(byte_t'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				// Cut-off frame; the bytes that follow are taken as its remainder.
				send_byte(HDR0);
				send_byte(HDR1);
				n = $urandom_range(0, 20);
				for (i = 0; i < n; i++)
					send_byte(byte_t'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = idle_out ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready) && !hold_req);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("imu_frame_deframer_crc16 regression: fail");
		$finish;
	end

	initial begin : main
		int wait_cnt;
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		idle_in     = 1'b1;
		idle_out    = 1'b1;
		hold_req    = 1'b0;
		hold_cycles = 0;
		bytes_sent  = 0;
		errors      = 0;
		frame_pos   = POS_HUNT;
		running_crc = CRC_INIT;
		crc_low_byte = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_hunt();
		test_field_extremes();
		test_crc_errors();
		test_backpressure();
		test_random_stream();
		in_valid <= 1'b0;
		for (wait_cnt = 0; expected_frames.size() != 0 && wait_cnt < 2000; wait_cnt++)
			@(posedge clk);
		if (expected_frames.size() != 0)
			report_mismatch($sformatf("%0d good frames never came out",
				expected_frames.size()));
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("imu_frame_deframer_crc16 regression: pass");
		else
			$display("imu_frame_deframer_crc16 regression: fail");
		$finish;
	end

endmodule
